/* rtl/core/bhpl_pkg.sv */
`timescale 1ns / 1ps

package bhpl_pkg;

    // Histogram geometry
    localparam int SLICES         = 25;
    localparam int HIST_BINS      = 2500;
    localparam int BINS_PER_SLICE = HIST_BINS + 1;          // unit bins plus overflow
    localparam int MEM_DEPTH      = SLICES * BINS_PER_SLICE;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);

    // Field widths
    localparam int SLICE_W  = 5;
    localparam int BIN_W    = 12;
    localparam int COUNT_W  = 32;
    localparam int VERTEX_W = 16;
    localparam int CHARGE_W = 17;
    localparam int Q_W      = CHARGE_W - 1;
    localparam int PCT_W    = 16;
    localparam int STATUS_W = 2;

    // Datapath widths
    localparam int TOTAL_W = 44;
    localparam int D_W     = 4;                  // interpolation weight, 0..8
    localparam int CNUM_W  = TOTAL_W + 4;        // cumulative count times 16
    localparam int NUM_W   = 60;                 // scaled numerator of the division
    localparam int QUOT_W  = 15;                 // enough for the 25600 saturation limit

    // Stream widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 16;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEG_CHG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LOAD_ACK = 2'd3;

    // Fixed-point constants (vertex in 1/16 cm, charge in 1/16 unit)
    localparam int VERTEX_OFFSET = 800;                  // 50 cm
    localparam int SLICE_SHIFT   = 6;                    // 4 cm slices
    localparam int OVF_Q_START   = HIST_BINS * 16 - 8;   // first charge in the overflow bin
    localparam int OVF_CENTER    = HIST_BINS * 16;
    localparam int BIN_ROUND     = 8;
    localparam int PCT_FULL      = 25600;                // 100 percent in 1/256 units
    localparam int PCT_SCALE     = 1600;                 // 100 times the 1/16 weight scale

    typedef struct packed {
        logic                cmd;
        logic [SLICE_W-1:0]  slice_index;
        logic [BIN_W-1:0]    bin_index;
        logic [COUNT_W-1:0]  bin_count;
        logic [VERTEX_W-1:0] vertex;
        logic [CHARGE_W-1:0] charge_sum;
    } item_t;

    typedef struct packed {
        logic cap;
        logic setup;
        logic clr_step;
        logic ld_wr;
        logic walk_step;
        logic mix;
        logic scale;
        logic numer;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_load;
        logic skip;
        logic walk_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/bhpl_div.sv */
`timescale 1ns / 1ps

module bhpl_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [bhpl_pkg::NUM_W-1:0]         num,
    input  logic [bhpl_pkg::TOTAL_W-1:0]       den,
    output logic                               done,
    output logic [bhpl_pkg::QUOT_W-1:0]        quot,
    output logic                               sat
);

    localparam int CNT_W = $clog2(bhpl_pkg::NUM_W);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [bhpl_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [bhpl_pkg::TOTAL_W-1:0]    rem_reg, rem_next;
    logic [bhpl_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic                            sat_reg, sat_next;
    logic [bhpl_pkg::TOTAL_W:0]      trial;
    logic                            fits;

    // One restoring step per cycle, most significant numerator bit first
    always_comb begin
        trial     = {rem_reg, num_reg[bhpl_pkg::NUM_W-1]};
        fits      = trial >= {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
            quot_next = '0;
            sat_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next  = fits ? bhpl_pkg::TOTAL_W'(trial - {1'b0, den})
                             : trial[bhpl_pkg::TOTAL_W-1:0];
            num_next  = {num_reg[bhpl_pkg::NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[bhpl_pkg::QUOT_W-2:0], fits};
            // a bit pushed past the top means the quotient is beyond the limit
            sat_next  = sat_reg | quot_reg[bhpl_pkg::QUOT_W-1];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bhpl_pkg::NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

/* rtl/core/bhpl_datapath.sv */
`timescale 1ns / 1ps

module bhpl_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bhpl_pkg::item_t                      item_in,
    input  bhpl_pkg::ctrl_cmd_t                  cmd,
    output bhpl_pkg::dp_status_t                 status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bhpl_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [bhpl_pkg::STATUS_W-1:0]        m_tuser
);

    localparam int OFF_W = bhpl_pkg::VERTEX_W + 1;
    localparam int OSL_W = bhpl_pkg::VERTEX_W - bhpl_pkg::SLICE_SHIFT;

    // Bin count memory
    logic [bhpl_pkg::COUNT_W-1:0] mem [bhpl_pkg::MEM_DEPTH];
    logic [bhpl_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
    logic [bhpl_pkg::COUNT_W-1:0] wr_data, rdata_reg;
    logic                         wr_en;

    logic [bhpl_pkg::TOTAL_W-1:0] totals_reg [bhpl_pkg::SLICES];

    bhpl_pkg::item_t              item_reg;
    logic [bhpl_pkg::ADDR_W-1:0]  clr_addr_reg;
    logic [bhpl_pkg::ADDR_W-1:0]  addr_reg;
    logic [bhpl_pkg::BIN_W-1:0]   k_reg, walk_end_reg;
    logic                         pend_reg;
    logic [bhpl_pkg::TOTAL_W-1:0] norm_reg, acc_reg;
    logic [bhpl_pkg::COUNT_W-1:0] last_reg;
    logic [bhpl_pkg::D_W-1:0]     d_reg;
    logic                         up_reg, inr_reg, neg_reg, empty_reg;
    logic                         ld_ok_reg, ld_tot_reg;
    logic [bhpl_pkg::CNUM_W-1:0]  cnum_reg;
    logic [bhpl_pkg::NUM_W-1:0]   a_reg, b_reg, num_reg;
    logic                         res_neg_reg;
    logic                         m_tvalid_reg;
    logic [bhpl_pkg::PCT_W-1:0]   pct_reg;
    logic [bhpl_pkg::STATUS_W-1:0] stat_reg;

    // Setup decode
    logic [OFF_W-1:0]               off;
    logic [OSL_W-1:0]               off_sl;
    logic [bhpl_pkg::SLICE_W-1:0]   slice_q;
    logic [bhpl_pkg::TOTAL_W-1:0]   norm;
    logic [bhpl_pkg::Q_W-1:0]       q, qp, c1, dq;
    logic [bhpl_pkg::BIN_W-1:0]     bin, n_last;
    logic                           up, inr;
    logic                           ld_ok;
    logic [bhpl_pkg::ADDR_W-1:0]    ld_addr, base;

    // Mix and output
    logic [bhpl_pkg::TOTAL_W-1:0]   s1;
    logic [bhpl_pkg::CNUM_W-1:0]    dl, cnum;
    logic                           a_ge_b;
    logic [bhpl_pkg::NUM_W-1:0]     diff;
    logic                           div_done, div_sat;
    logic [bhpl_pkg::QUOT_W-1:0]    quot;
    logic [bhpl_pkg::PCT_W-1:0]     mag, pct;
    logic [bhpl_pkg::STATUS_W-1:0]  stat;
    logic                           out_free;

    always_comb begin
        // vertex to slice, clamped at both ends
        off    = {item_reg.vertex[bhpl_pkg::VERTEX_W-1], item_reg.vertex}
                 + OFF_W'(bhpl_pkg::VERTEX_OFFSET);
        off_sl = off[bhpl_pkg::VERTEX_W-1:bhpl_pkg::SLICE_SHIFT];
        if (off[OFF_W-1]) begin
            slice_q = '0;
        end else if (off_sl > OSL_W'(bhpl_pkg::SLICES - 1)) begin
            slice_q = bhpl_pkg::SLICE_W'(bhpl_pkg::SLICES - 1);
        end else begin
            slice_q = off_sl[bhpl_pkg::SLICE_W-1:0];
        end
        norm = totals_reg[slice_q];

        // charge to bin and interpolation neighbor
        q  = item_reg.charge_sum[bhpl_pkg::Q_W-1:0];
        qp = q + bhpl_pkg::Q_W'(bhpl_pkg::BIN_ROUND);
        if (q >= bhpl_pkg::Q_W'(bhpl_pkg::OVF_Q_START)) begin
            bin = bhpl_pkg::BIN_W'(bhpl_pkg::BINS_PER_SLICE);
            c1  = bhpl_pkg::Q_W'(bhpl_pkg::OVF_CENTER);
        end else begin
            bin = qp[bhpl_pkg::Q_W-1:4] + 1'b1;
            c1  = {qp[bhpl_pkg::Q_W-1:4], 4'b0000};
        end
        up     = q > c1;
        dq     = up ? q - c1 : c1 - q;
        inr    = up ? (bin <= bhpl_pkg::BIN_W'(bhpl_pkg::HIST_BINS - 1))
                    : (bin >= bhpl_pkg::BIN_W'(2));
        n_last = (up && inr) ? bin : bin - 1'b1;

        ld_ok   = (item_reg.slice_index < bhpl_pkg::SLICE_W'(bhpl_pkg::SLICES))
                  && (item_reg.bin_index != '0)
                  && (item_reg.bin_index <= bhpl_pkg::BIN_W'(bhpl_pkg::BINS_PER_SLICE));
        ld_addr = bhpl_pkg::ADDR_W'(item_reg.slice_index)
                  * bhpl_pkg::ADDR_W'(bhpl_pkg::BINS_PER_SLICE)
                  + bhpl_pkg::ADDR_W'(item_reg.bin_index) - 1'b1;
        base    = bhpl_pkg::ADDR_W'(slice_q) * bhpl_pkg::ADDR_W'(bhpl_pkg::BINS_PER_SLICE);
    end

    // Memory ports
    always_comb begin
        rd_addr = addr_reg + bhpl_pkg::ADDR_W'(k_reg);
        wr_en   = cmd.clr_step || (cmd.ld_wr && ld_ok_reg);
        wr_addr = cmd.clr_step ? clr_addr_reg : addr_reg;
        wr_data = cmd.clr_step ? '0 : item_reg.bin_count;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control counters and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < bhpl_pkg::SLICES; i++) begin
                totals_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.setup) begin
                k_reg <= '0;
            end else if (cmd.walk_step) begin
                k_reg <= k_reg + 1'b1;
            end
            pend_reg <= cmd.walk_step;
            if (cmd.ld_wr && ld_ok_reg && ld_tot_reg) begin
                totals_reg[item_reg.slice_index] <= totals_reg[item_reg.slice_index]
                    - bhpl_pkg::TOTAL_W'(rdata_reg)
                    + bhpl_pkg::TOTAL_W'(item_reg.bin_count);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Mix: cumulative count weighted toward the neighbor bin
    always_comb begin
        s1   = (up_reg && inr_reg) ? acc_reg - bhpl_pkg::TOTAL_W'(last_reg) : acc_reg;
        dl   = bhpl_pkg::CNUM_W'(last_reg) * bhpl_pkg::CNUM_W'(d_reg);
        cnum = {s1, 4'b0000};
        if (inr_reg) begin
            cnum = up_reg ? cnum + dl : cnum - dl;
        end
        a_ge_b = a_reg >= b_reg;
        diff   = a_ge_b ? a_reg - b_reg : b_reg - a_reg;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            item_reg <= item_in;
        end
        if (cmd.setup) begin
            addr_reg     <= (item_reg.cmd == bhpl_pkg::CMD_LOAD) ? ld_addr : base;
            norm_reg     <= norm;
            walk_end_reg <= n_last;
            d_reg        <= dq[bhpl_pkg::D_W-1:0];
            up_reg       <= up;
            inr_reg      <= inr;
            neg_reg      <= item_reg.charge_sum[bhpl_pkg::CHARGE_W-1];
            empty_reg    <= norm == '0;
            ld_ok_reg    <= ld_ok;
            ld_tot_reg   <= item_reg.bin_index <= bhpl_pkg::BIN_W'(bhpl_pkg::HIST_BINS);
            acc_reg      <= '0;
        end else if (pend_reg) begin
            acc_reg  <= acc_reg + bhpl_pkg::TOTAL_W'(rdata_reg);
            last_reg <= rdata_reg;
        end
        if (cmd.mix) begin
            cnum_reg <= cnum;
        end
        if (cmd.scale) begin
            a_reg <= bhpl_pkg::NUM_W'(norm_reg) * bhpl_pkg::NUM_W'(bhpl_pkg::PCT_FULL);
            b_reg <= bhpl_pkg::NUM_W'(cnum_reg) * bhpl_pkg::NUM_W'(bhpl_pkg::PCT_SCALE);
        end
        if (cmd.numer) begin
            num_reg     <= diff + bhpl_pkg::NUM_W'(norm_reg >> 1);
            res_neg_reg <= !a_ge_b;
        end
        if (cmd.out_load) begin
            pct_reg  <= pct;
            stat_reg <= stat;
        end
    end

    bhpl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (norm_reg),
        .done    (div_done),
        .quot    (quot),
        .sat     (div_sat)
    );

    // Result formatting, saturated to the full-scale limit
    always_comb begin
        if (div_sat || quot > bhpl_pkg::QUOT_W'(bhpl_pkg::PCT_FULL)) begin
            mag = bhpl_pkg::PCT_W'(bhpl_pkg::PCT_FULL);
        end else begin
            mag = bhpl_pkg::PCT_W'(quot);
        end
        priority if (item_reg.cmd == bhpl_pkg::CMD_LOAD) begin
            stat = bhpl_pkg::STATUS_LOAD_ACK;
            pct  = '0;
        end else if (neg_reg) begin
            stat = bhpl_pkg::STATUS_NEG_CHG;
            pct  = '0;
        end else if (empty_reg) begin
            stat = bhpl_pkg::STATUS_EMPTY;
            pct  = '0;
        end else begin
            stat = bhpl_pkg::STATUS_OK;
            pct  = res_neg_reg ? -mag : mag;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        status.clr_last  = clr_addr_reg == bhpl_pkg::ADDR_W'(bhpl_pkg::MEM_DEPTH - 1);
        status.is_load   = item_reg.cmd == bhpl_pkg::CMD_LOAD;
        status.skip      = neg_reg || empty_reg;
        status.walk_last = k_reg == walk_end_reg;
        status.div_done  = div_done;
        status.out_free  = out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pct_reg;
    assign m_tuser  = stat_reg;

endmodule

/* rtl/core/bhpl_ctrl.sv */
`timescale 1ns / 1ps

module bhpl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bhpl_pkg::dp_status_t  status,
    output bhpl_pkg::ctrl_cmd_t   cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_ROUTE = 4'd3;
    localparam logic [3:0] ST_LD_WR = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_MIX   = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_NUMER = 4'd9;
    localparam logic [3:0] ST_DIVGO = 4'd10;
    localparam logic [3:0] ST_DIVW  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE: begin
                priority if (status.is_load) begin
                    state_next = ST_LD_WR;
                end else if (status.skip) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_LD_WR: begin
                cmd.ld_wr  = 1'b1;
                state_next = ST_OUT;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MIX;
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_NUMER;
            end
            ST_NUMER: begin
                cmd.numer  = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/binned_histogram_percentile_lookup.sv */
`timescale 1ns / 1ps

// Binned histogram percentile lookup.
// Input stream (s_*): one item per command. s_tuser selects the command, 0 loads
// one bin count of one slice histogram, 1 asks for the percentile of a charge at
// a vertex. Result stream (m_*): exactly one item per input item, with the
// signed percentile in m_tdata and the status code in m_tuser.
// Sequence: a load passes the setup, route and write states before its result. A
// query runs a prefix walk that reads one stored bin per cycle from the count
// memory, then a 60-step restoring divider (one quotient bit per cycle) forms the
// percent. Negative charge and empty slice queries skip the walk and the divider.
// One item at a time.
// Reset: aresetn is synchronous, active low. After reset a clearing pass zeroes
// the count memory, one entry per cycle; s_tready stays low until it ends. Slice
// totals clear at once.
// Stall: the result sits in an output register; a new item is accepted while
// it waits. A finished result holds until m_tready takes the previous one.
module binned_histogram_percentile_lookup (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slice_index[4:0], bin_index[16:5], bin_count[48:17], vertex[64:49],
    // charge_sum[81:65], zero fill above
    input  logic [bhpl_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // percentile[15:0]
    output logic [bhpl_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [bhpl_pkg::STATUS_W-1:0]       m_tuser
);

    bhpl_pkg::item_t      item_in;
    bhpl_pkg::ctrl_cmd_t  cmd;
    bhpl_pkg::dp_status_t status;

    // Unpack the input item
    always_comb begin
        item_in.cmd         = s_tuser[0];
        item_in.slice_index = s_tdata[4:0];
        item_in.bin_index   = s_tdata[16:5];
        item_in.bin_count   = s_tdata[48:17];
        item_in.vertex      = s_tdata[64:49];
        item_in.charge_sum  = s_tdata[81:65];
    end

    bhpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bhpl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_in  (item_in),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
